### rtl/aradi_pkg.sv
// ----------------------------------------------------------------------------
// ARADI cipher package
// Types, constants and round functions shared by the ARADI block cipher core.
// ----------------------------------------------------------------------------
package aradi_pkg;

    localparam int MAX_ROUNDS = 16;
    localparam int RK_ROWS    = MAX_ROUNDS + 1;
    localparam int RND_W      = $clog2(RK_ROWS);
    localparam int ADDR_W     = 6;

    // Register indexes, taken from paddr[5:3].
    localparam logic [2:0] REG_KEY_PAIR_0 = 3'd0;
    localparam logic [2:0] REG_KEY_PAIR_1 = 3'd1;
    localparam logic [2:0] REG_KEY_PAIR_2 = 3'd2;
    localparam logic [2:0] REG_KEY_PAIR_3 = 3'd3;
    localparam logic [2:0] REG_ROUNDS     = 3'd4;

    localparam logic [4:0] ROUNDS_RESET = 5'd16;

    // Block modes carried in tuser.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // Rotation amounts of the linear layer, selected by round mod 4.
    localparam logic [3:0] ROT_A [4] = '{4'd11, 4'd10, 4'd9, 4'd8};
    localparam logic [3:0] ROT_B [4] = '{4'd8, 4'd9, 4'd4, 4'd9};
    localparam logic [3:0] ROT_C [4] = '{4'd14, 4'd11, 4'd14, 4'd7};

    typedef logic [31:0]      word_t;
    typedef logic [3:0][31:0] block_t;
    typedef logic [7:0][31:0] key_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCHED,
        ST_PRE,
        ST_ROUND
    } state_t;

    function automatic word_t rotr32(input word_t v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [15:0] rotl16(input logic [15:0] v, input logic [3:0] s);
        logic [31:0] d;
        d = {v, v} << s;
        return d[31:16];
    endfunction

    function automatic word_t lin_word(input word_t v, input logic [1:0] i);
        logic [15:0] u;
        logic [15:0] l;
        logic [15:0] u2;
        logic [15:0] l2;
        u  = v[31:16];
        l  = v[15:0];
        u2 = u ^ rotl16(u, ROT_A[i]) ^ rotl16(l, ROT_C[i]);
        l2 = l ^ rotl16(l, ROT_A[i]) ^ rotl16(u, ROT_B[i]);
        return {u2, l2};
    endfunction

    function automatic block_t lin_layer(input block_t b, input logic [1:0] i);
        block_t o;
        for (int p = 0; p < 4; p++)
        begin
            o[p] = lin_word(b[p], i);
        end
        return o;
    endfunction

    function automatic block_t sbox(input block_t b);
        block_t s;
        s = b;
        s[1] = s[1] ^ (s[0] & s[2]);
        s[3] = s[3] ^ (s[1] & s[2]);
        s[2] = s[2] ^ (s[0] & s[3]);
        s[0] = s[0] ^ (s[1] & s[3]);
        return s;
    endfunction

    function automatic block_t inv_sbox(input block_t b);
        block_t s;
        s = b;
        s[0] = s[0] ^ (s[1] & s[3]);
        s[2] = s[2] ^ (s[0] & s[3]);
        s[3] = s[3] ^ (s[1] & s[2]);
        s[1] = s[1] ^ (s[0] & s[2]);
        return s;
    endfunction

    // One step of the key schedule: paired M-transforms, counter, word swaps.
    function automatic key_t ks_step(input key_t k, input logic [RND_W-1:0] r);
        key_t  n;
        word_t t;
        n = k;
        for (int p = 0; p < 4; p++)
        begin
            t = rotr32(k[2*p], (p % 2 == 1) ? 23 : 31);
            n[2*p+1] = t ^ rotr32(k[2*p+1], (p % 2 == 1) ? 4 : 29) ^ k[2*p+1];
            n[2*p]   = t ^ k[2*p+1];
        end
        n[7] = n[7] ^ {{(32-RND_W){1'b0}}, r};
        if (r[0])
        begin
            t = n[1]; n[1] = n[4]; n[4] = t;
            t = n[3]; n[3] = n[6]; n[6] = t;
        end
        else
        begin
            t = n[1]; n[1] = n[2]; n[2] = t;
            t = n[5]; n[5] = n[6]; n[6] = t;
        end
        return n;
    endfunction

    function automatic logic [RND_W-1:0] clamp_rounds(input logic [4:0] rc);
        logic [RND_W-1:0] n;
        if (rc == 5'd0)
        begin
            n = RND_W'(1);
        end
        else if (rc > 5'(MAX_ROUNDS))
        begin
            n = RND_W'(MAX_ROUNDS);
        end
        else
        begin
            n = RND_W'(rc);
        end
        return n;
    endfunction

endpackage

### rtl/aradi_block_cipher.sv
// ----------------------------------------------------------------------------
// ARADI block cipher core
// Iterative 128-bit block, 256-bit key encrypt/decrypt with a round-key memory.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_*       in         tdata: in_w, in_x, in_y, in_z; tuser: mode (1 = decrypt)
//  m_*       out        tdata: out_w, out_x, out_y, out_z
//  APB       in/out     key_pair_0..3 at 0x00..0x18, round_count at 0x20
//
//  A block is taken only while the core is idle. For n rounds, the round-key memory is
//  first addressed, then one step runs per round key read from its single read port,
//  and the core returns to idle before it takes the next block. The first block after
//  a key write first writes all 17 rows of the round-key memory, one row per cycle.
//  Reset clears the control state and marks the keys as not scheduled. A finished
//  result waits in the output register; the last step holds until that register is free.
// ----------------------------------------------------------------------------
module aradi_block_cipher
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [127:0]                 s_tdata,   // in_w, in_x, in_y, in_z
    input  logic                         s_tuser,   // mode
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [127:0]                 m_tdata,   // out_w, out_x, out_y, out_z
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aradi_pkg::ADDR_W-1:0] paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready
);
    import aradi_pkg::*;

    state_t             state_reg, state_next;
    key_t               key_reg;
    logic [4:0]         rounds_reg;
    key_t               ks_reg, ks_next;
    logic [RND_W-1:0]   sched_reg, sched_next;
    logic               keys_ready_reg, keys_ready_next;
    block_t             s_reg, s_next;
    logic               dec_reg, dec_next;
    logic [RND_W-1:0]   n_reg, n_next;
    logic [RND_W-1:0]   rnd_reg, rnd_next;
    logic               first_reg, first_next;
    logic               out_valid_reg;
    block_t             out_data_reg;

    logic [127:0]       rk_mem [RK_ROWS];
    block_t             rk_rd_reg;
    logic               rk_we;
    block_t             rk_row;

    logic               cfg_wr;
    logic [2:0]         cfg_idx;
    logic               slot_free;
    logic               fin;
    block_t             fin_data;
    block_t             step;

    assign pready    = 1'b1;
    assign cfg_idx   = paddr[5:3];
    assign cfg_wr    = psel && penable && pwrite;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign slot_free = !out_valid_reg || m_tready;

    always_comb
    begin
        case (cfg_idx)
            REG_KEY_PAIR_0: prdata = {key_reg[0], key_reg[1]};
            REG_KEY_PAIR_1: prdata = {key_reg[2], key_reg[3]};
            REG_KEY_PAIR_2: prdata = {key_reg[4], key_reg[5]};
            REG_KEY_PAIR_3: prdata = {key_reg[6], key_reg[7]};
            REG_ROUNDS:     prdata = {59'd0, rounds_reg};
            default:        prdata = 64'd0;
        endcase
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg    <= '0;
            rounds_reg <= ROUNDS_RESET;
        end
        else if (cfg_wr)
        begin
            case (cfg_idx)
                REG_KEY_PAIR_0: {key_reg[0], key_reg[1]} <= pwdata;
                REG_KEY_PAIR_1: {key_reg[2], key_reg[3]} <= pwdata;
                REG_KEY_PAIR_2: {key_reg[4], key_reg[5]} <= pwdata;
                REG_KEY_PAIR_3: {key_reg[6], key_reg[7]} <= pwdata;
                REG_ROUNDS:     rounds_reg <= pwdata[4:0];
                default:        ;
            endcase
        end
    end

    // Round-key memory: one row of four words per round key.
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[sched_reg] <= rk_row;
        end
        rk_rd_reg <= rk_mem[rnd_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            keys_ready_reg <= 1'b0;
            sched_reg      <= '0;
            rnd_reg        <= '0;
            first_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            keys_ready_reg <= keys_ready_next;
            sched_reg      <= sched_next;
            rnd_reg        <= rnd_next;
            first_reg      <= first_next;
            if (fin)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ks_reg  <= ks_next;
        s_reg   <= s_next;
        dec_reg <= dec_next;
        n_reg   <= n_next;
        if (fin)
        begin
            out_data_reg <= fin_data;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        keys_ready_next = keys_ready_reg;
        ks_next         = ks_reg;
        sched_next      = sched_reg;
        s_next          = s_reg;
        dec_next        = dec_reg;
        n_next          = n_reg;
        rnd_next        = rnd_reg;
        first_next      = first_reg;
        rk_we           = 1'b0;
        rk_row          = sched_reg[0] ? ks_reg[7:4] : ks_reg[3:0];
        fin             = 1'b0;
        fin_data        = s_reg ^ rk_rd_reg;
        step            = s_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    s_next   = s_tdata;
                    dec_next = (s_tuser == MODE_DECRYPT);
                    n_next   = clamp_rounds(rounds_reg);
                    if (keys_ready_reg)
                    begin
                        state_next = ST_PRE;
                    end
                    else
                    begin
                        ks_next    = key_reg;
                        sched_next = '0;
                        state_next = ST_SCHED;
                    end
                end
            end
            ST_SCHED:
            begin
                rk_we = 1'b1;
                if (sched_reg == RND_W'(MAX_ROUNDS))
                begin
                    keys_ready_next = 1'b1;
                    state_next      = ST_PRE;
                end
                else
                begin
                    ks_next    = ks_step(ks_reg, sched_reg);
                    sched_next = sched_reg + RND_W'(1);
                end
            end
            ST_PRE:
            begin
                rnd_next   = dec_reg ? n_reg : '0;
                first_next = 1'b1;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                if (!dec_reg)
                begin
                    if (rnd_reg == n_reg)
                    begin
                        // Post-whitening with round key n.
                        if (slot_free)
                        begin
                            fin        = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        s_next   = lin_layer(sbox(s_reg ^ rk_rd_reg), rnd_reg[1:0]);
                        rnd_next = rnd_reg + RND_W'(1);
                    end
                end
                else if (first_reg)
                begin
                    s_next     = s_reg ^ rk_rd_reg;
                    first_next = 1'b0;
                    rnd_next   = rnd_reg - RND_W'(1);
                end
                else
                begin
                    step     = inv_sbox(lin_layer(s_reg, rnd_reg[1:0])) ^ rk_rd_reg;
                    fin_data = step;
                    if (rnd_reg == '0)
                    begin
                        if (slot_free)
                        begin
                            fin        = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        s_next   = step;
                        rnd_next = rnd_reg - RND_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any key write invalidates the stored round keys.
        if (cfg_wr && (cfg_idx == REG_KEY_PAIR_0 || cfg_idx == REG_KEY_PAIR_1 ||
                       cfg_idx == REG_KEY_PAIR_2 || cfg_idx == REG_KEY_PAIR_3))
        begin
            keys_ready_next = 1'b0;
        end
    end

    a_round_needs_keys: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> keys_ready_reg)
        else $error("round step without a scheduled key set");

    a_round_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> (rnd_reg <= n_reg))
        else $error("round counter beyond the round count");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        fin |-> (!out_valid_reg || m_tready))
        else $error("result overwrites an undelivered transaction");

    a_sched_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCHED && sched_reg == RND_W'(MAX_ROUNDS) && !cfg_wr)
        |=> (state_reg == ST_PRE && keys_ready_reg))
        else $error("key schedule did not complete");

endmodule
